>>> hdl/clnw_pkg.sv
// clnw_pkg: shared types, op codes, init sequence and glyph table for the
// character lcd nibble writer; no dependencies
package clnw_pkg;

    // op codes of an input item
    localparam logic [2:0] OP_INIT      = 3'd0;
    localparam logic [2:0] OP_COMMAND   = 3'd1;
    localparam logic [2:0] OP_CHAR      = 3'd2;
    localparam logic [2:0] OP_DISP_ADDR = 3'd3;
    localparam logic [2:0] OP_GLYPH_ADR = 3'd4;

    // register select values
    localparam logic RS_INSTR = 1'b0;
    localparam logic RS_DATA  = 1'b1;

    // command prefixes and masks
    localparam logic [7:0] CMD_DISP_ADDR  = 8'h80;
    localparam logic [7:0] CMD_GLYPH_ADDR = 8'h40;
    localparam logic [7:0] DISP_ADDR_MASK = 8'h7f;
    localparam logic [7:0] GLYPH_ADR_MASK = 8'h3f;
    localparam logic [7:0] GLYPH_FIRST    = 8'd192;

    // reset value of the function-set register
    localparam logic [7:0] FUNC_SET_RESET = 8'h28;

    // init sequence
    localparam int         INIT_LEN  = 9;
    localparam int         IDX_W     = $clog2(INIT_LEN);
    localparam logic [IDX_W-1:0] INIT_LAST = IDX_W'(INIT_LEN - 1);

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // widths of the stream payloads
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    // one queued job: a single byte or the whole init sequence
    typedef struct packed {
        logic       init;
        logic       rs;
        logic [7:0] data;
    } t_entry;

    // remap of character codes 192..255
    localparam logic [7:0] GLYPH_MAP [64] = '{
        8'h41, 8'ha0, 8'h42, 8'ha1, 8'he0, 8'h45, 8'ha3, 8'ha4,
        8'ha5, 8'ha6, 8'h4b, 8'ha7, 8'h4d, 8'h48, 8'h4f, 8'ha8,
        8'h50, 8'h43, 8'h54, 8'ha9, 8'haa, 8'h58, 8'he1, 8'hab,
        8'hac, 8'he2, 8'had, 8'hae, 8'h62, 8'haf, 8'hb0, 8'hb1,
        8'h61, 8'hb2, 8'hb3, 8'hb4, 8'he3, 8'h65, 8'hb6, 8'hb7,
        8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'h6f, 8'hbe,
        8'h70, 8'h63, 8'hbf, 8'h79, 8'he4, 8'h78, 8'he5, 8'hc0,
        8'hc1, 8'he6, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7
    };

    // byte of the power-up sequence at a given step
    function automatic logic [7:0] init_byte(input logic [IDX_W-1:0] idx,
                                             input logic [7:0] func_set);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h30;
            4'd1:    b = 8'h30;
            4'd2:    b = 8'h32;
            4'd3:    b = func_set;
            4'd4:    b = 8'h08;
            4'd5:    b = 8'h0f;
            4'd6:    b = 8'h01;
            4'd7:    b = 8'h04;
            4'd8:    b = 8'h80;
            default: b = 8'h80;
        endcase
        return b;
    endfunction

endpackage

>>> hdl/clnw_front.sv
// clnw_front: decodes input items into queue jobs, remaps characters and
// builds address commands; depends on clnw_pkg
module clnw_front (
    input  logic                     i_valid,
    input  logic [2:0]               i_op,
    input  logic [7:0]               i_value,
    output logic                     o_push,
    output clnw_pkg::t_entry         o_entry
);

    // classify the op and form the byte to send
    always_comb begin
        o_push       = i_valid;
        o_entry.init = 1'b0;
        o_entry.rs   = clnw_pkg::RS_INSTR;
        o_entry.data = i_value;
        unique case (i_op)
            clnw_pkg::OP_INIT: begin
                o_entry.init = 1'b1;
            end
            clnw_pkg::OP_COMMAND: begin
                o_entry.data = i_value;
            end
            clnw_pkg::OP_CHAR: begin
                o_entry.rs = clnw_pkg::RS_DATA;
                if (i_value >= clnw_pkg::GLYPH_FIRST) begin
                    o_entry.data = clnw_pkg::GLYPH_MAP[i_value[5:0]];
                end
            end
            clnw_pkg::OP_DISP_ADDR: begin
                o_entry.data = clnw_pkg::CMD_DISP_ADDR | (i_value & clnw_pkg::DISP_ADDR_MASK);
            end
            clnw_pkg::OP_GLYPH_ADR: begin
                o_entry.data = clnw_pkg::CMD_GLYPH_ADDR | (i_value & clnw_pkg::GLYPH_ADR_MASK);
            end
            default: begin
                // unknown op: item is consumed with no output
                o_push = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/clnw_fifo.sv
// clnw_fifo: small job queue between the front decoder and the back
// serializer; depends on clnw_pkg
module clnw_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  clnw_pkg::t_entry     i_entry,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output clnw_pkg::t_entry     o_entry
);

    clnw_pkg::t_entry                r_mem [clnw_pkg::Q_DEPTH];
    logic [clnw_pkg::Q_PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [clnw_pkg::Q_PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [clnw_pkg::Q_PTR_W:0]      r_count, n_count;
    logic                            do_push, do_pop;

    assign o_full  = (r_count == (clnw_pkg::Q_PTR_W+1)'(clnw_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

>>> hdl/clnw_back.sv
// clnw_back: takes jobs from the queue and sends them as nibbles, high first,
// through an output register; depends on clnw_pkg
module clnw_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_function_set,
    input  logic                 i_q_valid,
    input  clnw_pkg::t_entry     i_q_entry,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_rs,
    output logic [3:0]           o_nibble,
    output logic                 o_last
);

    logic                          r_cur_valid;
    clnw_pkg::t_entry              r_cur;
    logic [clnw_pkg::IDX_W-1:0]    r_idx;
    logic                          r_lo;
    logic                          r_out_valid;
    logic                          r_out_rs;
    logic [3:0]                    r_out_nib;
    logic                          r_out_last;

    logic [7:0] cur_byte;
    logic       cur_last;
    logic       advance;

    // byte and last flag of the current nibble
    always_comb begin
        cur_byte = r_cur.init ? clnw_pkg::init_byte(r_idx, i_function_set) : r_cur.data;
        cur_last = r_lo && (!r_cur.init || (r_idx == clnw_pkg::INIT_LAST));
        advance  = r_cur_valid && (!r_out_valid || i_ready);
        o_q_pop  = !r_cur_valid || (advance && cur_last);
    end

    // job register and step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= '0;
            r_lo        <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_cur_valid <= i_q_valid;
                r_idx       <= '0;
                r_lo        <= 1'b0;
            end else if (advance) begin
                r_lo <= !r_lo;
                if (r_lo) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_entry;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_rs   <= r_cur.rs;
            r_out_nib  <= r_lo ? cur_byte[3:0] : cur_byte[7:4];
            r_out_last <= cur_last;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_rs     = r_out_rs;
    assign o_nibble = r_out_nib;
    assign o_last   = r_out_last;

endmodule

>>> hdl/char_lcd_nibble_writer_core.sv
// an accepted item passes the job queue and the job register on its way to the output register
// throughput: one nibble per cycle while the output side is ready; a byte op is two nibbles, init is 18
// input side takes one item per cycle while the 4-entry job queue has room
// reset: synchronous active low; clears queue, serializer and output valid,
// function-set register returns to 0x28
// top level of the character lcd nibble writer; depends on clnw_pkg,
// clnw_front, clnw_fifo and clnw_back
module char_lcd_nibble_writer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [7:0]                        i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [clnw_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // value[7:0]
    input  logic [clnw_pkg::S_TUSER_W-1:0]    s_axis_tuser,  // op[2:0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [clnw_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // nibble[3:0], zero pad
    output logic                              m_axis_tuser,  // reg_select[0]
    output logic                              m_axis_tlast
);

    logic                 r_function_set_vld;
    logic [7:0]           r_function_set;
    logic                 front_push;
    clnw_pkg::t_entry     front_entry;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    clnw_pkg::t_entry     q_entry;
    logic [3:0]           out_nib;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_function_set     <= clnw_pkg::FUNC_SET_RESET;
            r_function_set_vld <= 1'b0;
        end else begin
            r_function_set_vld <= 1'b1;
            if (i_cfg_wen) begin
                r_function_set <= i_cfg_wdata;
            end
        end
    end

    assign s_axis_tready = !q_full;

    // decode
    clnw_front u_front (
        .i_valid (s_axis_tvalid && s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_value (s_axis_tdata),
        .o_push  (front_push),
        .o_entry (front_entry)
    );

    // job queue
    clnw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // serializer
    clnw_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_function_set (r_function_set),
        .i_q_valid      (q_valid),
        .i_q_entry      (q_entry),
        .o_q_pop        (q_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_rs           (m_axis_tuser),
        .o_nibble       (out_nib),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {{(clnw_pkg::M_TDATA_W-4){1'b0}}, out_nib};

`ifndef SYNTHESIS
    // a full queue is never empty
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> q_valid)
        else $error("queue full while empty");

    // the queue is pushed only for an accepted item
    a_push_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |-> (s_axis_tvalid && s_axis_tready))
        else $error("queue push without accepted item");

    // function-set register reloads its reset value
    a_cfg_reset: assert property (@(posedge i_clk)
        (r_function_set_vld == 1'b0 && $past(!i_rst_n)) |->
            r_function_set == clnw_pkg::FUNC_SET_RESET)
        else $error("function-set reset value wrong");
`endif

endmodule

>>> sim/clnw_checker.sv
// clnw_checker: watches the request and nibble streams of the character lcd
// nibble writer, predicts every strobe and compares; depends on clnw_pkg
module clnw_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [7:0]                        i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [clnw_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // value[7:0]
    input  logic [clnw_pkg::S_TUSER_W-1:0]    s_axis_tuser,  // op[2:0]
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [clnw_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // nibble[3:0], zero pad
    input  logic                              m_axis_tuser,  // reg_select[0]
    input  logic                              m_axis_tlast,
    output int                                o_pending,
    output int                                o_fail_count
);

    // keep the log short when the block is badly off
    localparam int REPORT_MAX = 40;

    // remap of character codes 192..255, index 0 is code 192
    localparam logic [0:63][7:0] CYR_GLYPH = {
        8'h41, 8'ha0, 8'h42, 8'ha1, 8'he0, 8'h45, 8'ha3, 8'ha4,
        8'ha5, 8'ha6, 8'h4b, 8'ha7, 8'h4d, 8'h48, 8'h4f, 8'ha8,
        8'h50, 8'h43, 8'h54, 8'ha9, 8'haa, 8'h58, 8'he1, 8'hab,
        8'hac, 8'he2, 8'had, 8'hae, 8'h62, 8'haf, 8'hb0, 8'hb1,
        8'h61, 8'hb2, 8'hb3, 8'hb4, 8'he3, 8'h65, 8'hb6, 8'hb7,
        8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'h6f, 8'hbe,
        8'h70, 8'h63, 8'hbf, 8'h79, 8'he4, 8'h78, 8'he5, 8'hc0,
        8'hc1, 8'he6, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7
    };

    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic       last;
    } t_strobe;

    t_strobe    due_strobes[$];
    logic [7:0] func_set;
    int         fails = 0;

    // one byte goes out as two strobes, high nibble first
    task automatic queue_byte(input logic rs, input logic [7:0] b, input logic is_last);
        due_strobes.push_back('{rs: rs, nibble: b[7:4], last: 1'b0});
        due_strobes.push_back('{rs: rs, nibble: b[3:0], last: is_last});
    endtask

    // strobes that one request causes
    task automatic plan_strobes(input logic [2:0] op, input logic [7:0] v);
        logic [7:0] wake [9];
        logic [7:0] ch;
        wake = '{8'h30, 8'h30, 8'h32, func_set, 8'h08, 8'h0f, 8'h01, 8'h04, 8'h80};
        unique case (op)
            clnw_pkg::OP_INIT: begin
                for (int i = 0; i < 9; i++)
                    queue_byte(clnw_pkg::RS_INSTR, wake[i], i == 8);
            end
            clnw_pkg::OP_COMMAND: queue_byte(clnw_pkg::RS_INSTR, v, 1'b1);
            clnw_pkg::OP_CHAR: begin
                ch = (v >= clnw_pkg::GLYPH_FIRST) ?
                     CYR_GLYPH[6'(v - clnw_pkg::GLYPH_FIRST)] : v;
                queue_byte(clnw_pkg::RS_DATA, ch, 1'b1);
            end
            clnw_pkg::OP_DISP_ADDR:
                queue_byte(clnw_pkg::RS_INSTR, 8'h80 | (v & 8'h7f), 1'b1);
            clnw_pkg::OP_GLYPH_ADR:
                queue_byte(clnw_pkg::RS_INSTR, 8'h40 | (v & 8'h3f), 1'b1);
            default: ;  // spare op codes cause nothing
        endcase
    endtask

    task automatic flag(input string field, input int want, input int got);
        fails++;
        if (fails <= REPORT_MAX)
            $error("%s: expected %0h, got %0h", field, want, got);
    endtask

    // result side first, then the new request
    always @(posedge i_clk) begin
        t_strobe want;
        if (!i_rst_n) begin
            due_strobes.delete();
            func_set = clnw_pkg::FUNC_SET_RESET;
        end else begin
            if (i_cfg_wen)
                func_set = i_cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_strobes.size() == 0) begin
                    flag("unexpected item, nibble", 0, m_axis_tdata[3:0]);
                end else begin
                    want = due_strobes.pop_front();
                    if (m_axis_tuser !== want.rs)
                        flag("reg_select", want.rs, m_axis_tuser);
                    if (m_axis_tdata[3:0] !== want.nibble)
                        flag("nibble", want.nibble, m_axis_tdata[3:0]);
                    if (m_axis_tlast !== want.last)
                        flag("last", want.last, m_axis_tlast);
                    if (m_axis_tdata[clnw_pkg::M_TDATA_W-1:4] !== '0)
                        flag("tdata pad", 0, m_axis_tdata[clnw_pkg::M_TDATA_W-1:4]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                plan_strobes(s_axis_tuser, s_axis_tdata);
        end
        o_pending    <= due_strobes.size();
        o_fail_count <= fails;
    end

endmodule

>>> sim/char_lcd_nibble_writer_core_test.sv
// char_lcd_nibble_writer_core_test: drives requests and function-set writes
// into the lcd nibble writer and gives the verdict; depends on clnw_pkg,
// clnw_checker and the block itself
module char_lcd_nibble_writer_core_test;

    localparam int         LIMIT_CYCLES = 400000;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         RAND_ITEMS   = 17;
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_wen = 1'b0;
    logic [7:0]                     i_cfg_wdata = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [clnw_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;  // value[7:0]
    logic [clnw_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;  // op[2:0]
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [clnw_pkg::M_TDATA_W-1:0] m_axis_tdata;       // nibble[3:0], zero pad
    logic                           m_axis_tuser;       // reg_select[0]
    logic                           m_axis_tlast;

    int   pending;
    int   fail_count;
    int   cycles = 0;
    int   stall_left = 0;
    logic idle_on = 1'b1;

    char_lcd_nibble_writer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    clnw_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // lcd side stalls at random
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            m_axis_tready <= 1'b0;
            stall_left    <= idle_len() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one request item, with an optional gap ahead of it
    task automatic send_item(input logic [2:0] op, input logic [7:0] v);
        int gap;
        gap = (idle_on && $urandom_range(0, 1)) ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drain every expected nibble, then let the block idle before going on
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_func_set(input logic [7:0] v);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    initial begin
        logic [7:0] func_vals [5];
        logic [2:0] op;
        int         r;
        func_vals = '{8'h00, 8'hff, 8'($urandom), 8'($urandom),
                      clnw_pkg::FUNC_SET_RESET};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every op, field extremes, glyph remap edges, spare ops
        send_item(clnw_pkg::OP_INIT, 8'h00);
        send_item(clnw_pkg::OP_COMMAND, 8'h00);
        send_item(clnw_pkg::OP_COMMAND, 8'hff);
        send_item(clnw_pkg::OP_COMMAND, 8'ha5);
        send_item(clnw_pkg::OP_CHAR, 8'h00);
        send_item(clnw_pkg::OP_CHAR, 8'h41);
        send_item(clnw_pkg::OP_CHAR, 8'd191);
        send_item(clnw_pkg::OP_CHAR, 8'd192);
        send_item(clnw_pkg::OP_CHAR, 8'he0);
        send_item(clnw_pkg::OP_CHAR, 8'hff);
        send_item(clnw_pkg::OP_DISP_ADDR, 8'h00);
        send_item(clnw_pkg::OP_DISP_ADDR, 8'h7f);
        send_item(clnw_pkg::OP_DISP_ADDR, 8'hff);
        send_item(clnw_pkg::OP_GLYPH_ADR, 8'h00);
        send_item(clnw_pkg::OP_GLYPH_ADR, 8'h3f);
        send_item(clnw_pkg::OP_GLYPH_ADR, 8'hc0);
        send_item(clnw_pkg::OP_GLYPH_ADR, 8'hff);
        for (op = OP_SPARE_LO; op != clnw_pkg::OP_INIT; op = op + 1'b1)
            send_item(op, 8'($urandom));
        send_item(OP_SPARE_HI, 8'hff);
        send_item(clnw_pkg::OP_CHAR, 8'h5a);

        // phases over function-set values, one of them without idling
        for (int p = 0; p < 5; p++) begin
            settle();
            idle_on = (p != 2);
            write_func_set(func_vals[p]);
            send_item(clnw_pkg::OP_INIT, 8'($urandom));
            for (int n = 0; n < RAND_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 6)       op = clnw_pkg::OP_INIT;
                else if (r < 28) op = clnw_pkg::OP_COMMAND;
                else if (r < 65) op = clnw_pkg::OP_CHAR;
                else if (r < 80) op = clnw_pkg::OP_DISP_ADDR;
                else if (r < 93) op = clnw_pkg::OP_GLYPH_ADR;
                else             op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                send_item(op, 8'($urandom));
            end
        end

        settle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
